@@ hdl/pee_pkg.sv @@
package pee_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [31:0] VALUE_ERR = 32'hFFFF_FFFF;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_MISSING = 2'd1;
  localparam status_t ST_EMPTY   = 2'd2;
  localparam status_t ST_OVF     = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch incoming word
    logic acc_upd;    // acc = acc*10 + digit
    logic push_acc;   // push accumulator, clear number state
    logic push_res;   // push operator result
    logic set_err_op; // missing operand
    logic rd_en;      // stack read
    logic rd_second;  // 0: top, 1: one below top
    logic ld_b;       // rhs <= read data
    logic ld_a;       // lhs <= read data
    logic pop2;       // drop two entries
    logic exec;       // evaluate + - *, or launch divide
    logic div_take;   // capture quotient
    logic load_out;   // fill output register, clear expression state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic err_nz;
    logic is_digit;
    logic is_op;
    logic op_div;
    logic in_number;
    logic cnt_lt2;
    logic last;
    logic div_done;
    logic slot_free;
  } sts_t;

endpackage

@@ hdl/pee_if.sv @@
interface pee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface pee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

@@ hdl/pee_div.sv @@
module pee_div import pee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] q_r;
  logic [31:0] d_r;
  logic        neg_r;
  logic        zero_r;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_r, q_r[31]};
  assign diff    = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring divide on magnitudes, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      q_r    <= dividend[31] ? 32'd0 - dividend : dividend;
      d_r    <= divisor[31] ? 32'd0 - divisor : divisor;
      neg_r  <= dividend[31] ^ divisor[31];
      zero_r <= (divisor == 32'd0);
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= shifted[31:0];
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = zero_r ? VALUE_ERR : (neg_r ? 32'd0 - q_r : q_r);

endmodule

@@ hdl/pee_datapath.sv @@
module pee_datapath import pee_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [7:0]         in_symbol,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [31:0]   stack_mem [STACK_DEPTH];
  logic [CW-1:0] count_r;
  logic [31:0]   acc_r;
  logic          in_num_r;
  status_t       err_r;
  logic [7:0]    sym_r;
  logic          last_r;
  logic [31:0]   rdata_r;
  logic [31:0]   a_r;
  logic [31:0]   b_r;
  logic [31:0]   res_r;
  logic          out_valid_r;
  logic [31:0]   out_value_r;
  status_t       out_status_r;

  logic          is_digit;
  logic          is_op;
  logic          do_push;
  logic [31:0]   push_val;
  logic          full;
  logic [CW-1:0] rd_cnt;
  logic [AW-1:0] rd_addr;
  logic [7:0]    digit;
  logic          div_done;
  logic [31:0]   div_q;
  logic          div_start;
  logic          slot_free;

  always_comb begin
    is_digit = sym_r inside {[CH_ZERO:CH_NINE]};
    is_op    = sym_r inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  end

  assign digit     = sym_r - CH_ZERO;
  assign full      = (count_r == CW'(STACK_DEPTH));
  assign do_push   = cmd.push_acc | cmd.push_res;
  assign push_val  = cmd.push_acc ? acc_r : res_r;
  assign rd_cnt    = count_r - (cmd.rd_second ? CW'(2) : CW'(1));
  assign rd_addr   = rd_cnt[AW-1:0];
  assign div_start = cmd.exec && (sym_r == CH_SLASH);
  assign slot_free = !out_valid_r || out_ready;

  pee_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (a_r),
    .divisor  (b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // stack storage
  always_ff @(posedge clk) begin
    if (do_push && !full) begin
      stack_mem[count_r[AW-1:0]] <= push_val;
    end
    if (cmd.rd_en) begin
      rdata_r <= stack_mem[rd_addr];
    end
  end

  // expression control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      acc_r    <= '0;
      in_num_r <= 1'b0;
      err_r    <= ST_OK;
    end else if (cmd.load_out) begin
      count_r  <= '0;
      acc_r    <= '0;
      in_num_r <= 1'b0;
      err_r    <= ST_OK;
    end else begin
      if (cmd.acc_upd) begin
        acc_r    <= {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0} + {24'd0, digit};
        in_num_r <= 1'b1;
      end
      if (cmd.push_acc) begin
        acc_r    <= '0;
        in_num_r <= 1'b0;
      end
      if (do_push) begin
        if (full) begin
          err_r <= ST_OVF;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.pop2) begin
        count_r <= count_r - CW'(2);
      end
      if (cmd.set_err_op) begin
        err_r <= ST_MISSING;
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sym_r  <= in_symbol;
      last_r <= in_last;
    end
    if (cmd.ld_b) begin
      b_r <= rdata_r;
    end
    if (cmd.ld_a) begin
      a_r <= rdata_r;
    end
    if (cmd.exec) begin
      case (sym_r)
        CH_PLUS:  res_r <= a_r + b_r;
        CH_MINUS: res_r <= a_r - b_r;
        CH_STAR:  res_r <= a_r * b_r;
        default:  res_r <= res_r;
      endcase
    end else if (cmd.div_take) begin
      res_r <= div_q;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (err_r != ST_OK) begin
        out_value_r  <= VALUE_ERR;
        out_status_r <= err_r;
      end else if (count_r == '0) begin
        out_value_r  <= VALUE_ERR;
        out_status_r <= ST_EMPTY;
      end else begin
        out_value_r  <= rdata_r;
        out_status_r <= ST_OK;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  always_comb begin
    sts.err_nz    = (err_r != ST_OK);
    sts.is_digit  = is_digit;
    sts.is_op     = is_op;
    sts.op_div    = (sym_r == CH_SLASH);
    sts.in_number = in_num_r;
    sts.cnt_lt2   = (count_r < CW'(2));
    sts.last      = last_r;
    sts.div_done  = div_done;
    sts.slot_free = slot_free;
  end

endmodule

@@ hdl/pee_ctrl.sv @@
module pee_ctrl import pee_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_OPCHK,
    S_RD1,
    S_RD2,
    S_EXEC,
    S_DIV,
    S_PUSHRES,
    S_ENDCHK,
    S_TOP,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.err_nz) begin
          state_nxt = S_TOP;
        end else if (sts.is_digit) begin
          cmd.acc_upd = 1'b1;
          state_nxt   = S_ENDCHK;
        end else begin
          cmd.push_acc = sts.in_number;
          state_nxt    = S_OPCHK;
        end
      end
      S_OPCHK: begin
        if (!sts.err_nz && sts.is_op) begin
          if (sts.cnt_lt2) begin
            cmd.set_err_op = 1'b1;
            state_nxt      = S_TOP;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = S_RD1;
          end
        end else begin
          state_nxt = S_ENDCHK;
        end
      end
      S_RD1: begin
        cmd.ld_b      = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_second = 1'b1;
        state_nxt     = S_RD2;
      end
      S_RD2: begin
        cmd.ld_a  = 1'b1;
        cmd.pop2  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.op_div ? S_DIV : S_PUSHRES;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_PUSHRES;
        end
      end
      S_PUSHRES: begin
        cmd.push_res = 1'b1;
        state_nxt    = S_TOP;
      end
      S_ENDCHK: begin
        cmd.push_acc = sts.last && sts.in_number && !sts.err_nz;
        state_nxt    = S_TOP;
      end
      S_TOP: begin
        if (sts.last) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

@@ hdl/postfix_expression_evaluator_top.sv @@
// Channel  Dir  Word                        Handshake
// in_ch    in   symbol[7:0], last           valid/ready
// out_ch   out  value[31:0] signed, status  valid/ready
//
// One character is taken at a time; ready is high only while no character
// is in flight. A digit updates the accumulator, a delimiter pushes any number;
// + - * pop two operands and push the result, / via the bit-per-cycle divider
// (32 steps). A character that arrives after an error is dropped. The final
// character adds the output load, issued off the top-of-stack read.
// Reset (rst_n low, synchronous) empties the stack and clears the number
// and error state; the stack memory itself is not cleared.
// The result sits in an output register, so the next character is taken
// while it waits; only a second final character stalls until it drains.
module postfix_expression_evaluator_top import pee_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input logic             clk,
  input logic             rst_n,
  pee_in_if.sink          in_ch,
  pee_out_if.source       out_ch
);

  cmd_t cmd;
  sts_t sts;

  pee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pee_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_symbol  (in_ch.symbol),
    .in_last    (in_ch.last),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_value  (out_ch.value),
    .out_status (out_ch.status)
  );

  // any error status carries the all-ones value
  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.value == -32'sd1)
    else $error("error status without -1 value");

  // one character at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second character accepted while busy");

  // divider only finishes while a character is in flight
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> !in_ch.ready)
    else $error("divide done while idle");

endmodule
